@@ src/sliding_window_min_max_mean_defines.svh @@
// assertion macros for the sliding window min/max/mean block
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef SLIDING_WINDOW_MIN_MAX_MEAN_DEFINES_SVH
`define SLIDING_WINDOW_MIN_MAX_MEAN_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SWMM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("swmm assertion failed");
// next-cycle implication
`define SWMM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("swmm assertion failed");
`else
`define SWMM_ASSERT_IMPL(lbl, ante, cons)
`define SWMM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ src/swmm_pkg.sv @@
// shared constants, sequencer step codes and control store for the
// sliding window min/max/mean block; no dependencies
package swmm_pkg;

  // window geometry and sample format
  localparam int WINDOW      = 256;
  localparam int SAMPLE_BITS = 20;
  localparam int IDX_W       = $clog2(WINDOW);
  localparam int CNT_W       = $clog2(WINDOW + 1);
  localparam int SUM_W       = SAMPLE_BITS + IDX_W;

  // stream payload widths, padded to whole bytes
  localparam int IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_W       = 3 * SAMPLE_BITS + CNT_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  // divider iteration counter
  localparam int DIV_CNT_W   = $clog2(SUM_W + 1);

  // sequencer steps, in program order
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVRD,
    ST_UPD,
    ST_CHK,
    ST_SCAN0,
    ST_SCANL,
    ST_LOAD,
    ST_FIN
  } swmm_step_e;

  // jump conditions
  typedef enum logic [2:0] {
    JC_NONE,
    JC_NO_IN,
    JC_NO_SCAN,
    JC_SCAN_MORE,
    JC_DIV_BUSY,
    JC_OUT_FULL
  } swmm_jc_e;

  // one control word
  typedef struct packed {
    logic       in_rdy;
    logic       ev_rd;
    logic       upd;
    logic       chk;
    logic       scan_init;
    logic       scan_step;
    logic       load;
    logic       fin;
    swmm_jc_e   cond;
    swmm_step_e target;
  } swmm_cw_t;

  // control store: jump to target when cond holds, else fall through
  function automatic swmm_cw_t swmm_rom(swmm_step_e step);
    swmm_cw_t cw;
    cw        = '0;
    cw.cond   = JC_NONE;
    cw.target = ST_IDLE;
    unique case (step)
      ST_IDLE: begin
        cw.in_rdy = 1'b1;
        cw.cond   = JC_NO_IN;
        cw.target = ST_IDLE;
      end
      ST_EVRD: cw.ev_rd = 1'b1;
      ST_UPD:  cw.upd   = 1'b1;
      ST_CHK: begin
        cw.chk    = 1'b1;
        cw.cond   = JC_NO_SCAN;
        cw.target = ST_LOAD;
      end
      ST_SCAN0: cw.scan_init = 1'b1;
      ST_SCANL: begin
        cw.scan_step = 1'b1;
        cw.cond      = JC_SCAN_MORE;
        cw.target    = ST_SCANL;
      end
      ST_LOAD: begin
        cw.load   = 1'b1;
        cw.cond   = JC_DIV_BUSY;
        cw.target = ST_LOAD;
      end
      ST_FIN: begin
        cw.fin    = 1'b1;
        cw.cond   = JC_OUT_FULL;
        cw.target = ST_FIN;
      end
      default: cw = '0;
    endcase
    return cw;
  endfunction

endpackage

@@ src/swmm_div.sv @@
// restoring divider, one quotient bit per cycle, for the window mean
// depends on swmm_pkg for the sum, count and sample widths
module swmm_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [swmm_pkg::SUM_W-1:0]      dividend_i,
  input  logic [swmm_pkg::CNT_W-1:0]      divisor_i,
  output logic                            busy_o,
  output logic [swmm_pkg::SAMPLE_BITS-1:0] quotient_o
);
  import swmm_pkg::*;

  logic [DIV_CNT_W-1:0] cnt_q;
  logic [SUM_W-1:0]     dq_q;
  logic [CNT_W-1:0]     rem_q;
  logic [CNT_W-1:0]     div_q;
  logic [CNT_W:0]       trial;
  logic                 fits;

  // shift in the next dividend bit and try the subtract
  assign trial = {rem_q, dq_q[SUM_W-1]};
  assign fits  = trial >= (CNT_W + 1)'(div_q);

  // iteration counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= DIV_CNT_W'(SUM_W);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - DIV_CNT_W'(1);
    end
  end

  // dividend bits leave at the top, quotient bits enter at the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (cnt_q != '0) begin
      dq_q  <= {dq_q[SUM_W-2:0], fits};
      rem_q <= fits ? CNT_W'(trial - (CNT_W + 1)'(div_q)) : CNT_W'(trial);
    end
  end

  assign busy_o     = (cnt_q != '0);
  assign quotient_o = dq_q[SAMPLE_BITS-1:0];

endmodule

@@ src/sliding_window_min_max_mean.sv @@
// sliding window min/max/mean top level: sequencer, sample ring and extremes
// depends on swmm_pkg, swmm_div and sliding_window_min_max_mean_defines.svh
//
// One rate sample goes in, one result (mean, maximum, minimum, held count)
// comes out. The mean comes from a divider that yields one quotient bit per
// cycle over the 28-bit sum. When the held maximum or minimum has aged out
// of the window, the ring is read back one entry per cycle through its single
// read port; both extremes are found in the same pass and the divider runs
// alongside it. A finished result waits in the output register while the
// next sample is taken in.
module sliding_window_min_max_mean (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [19:0] rate_sample
  input  logic [swmm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [19:0] window_mean, [39:20] window_max, [59:40] window_min, [68:60] held_count
  output logic [swmm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
  import swmm_pkg::*;
  `include "sliding_window_min_max_mean_defines.svh"

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(WINDOW);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);

  // sequencer
  swmm_step_e step_q;
  swmm_step_e step_d;
  swmm_cw_t   cw;
  logic       jump;

  // window state
  logic [SAMPLE_BITS-1:0] sample_q;
  logic [IDX_W-1:0]       head_q;
  logic [CNT_W-1:0]       count_q;
  logic [SUM_W-1:0]       sum_q;
  logic [SAMPLE_BITS-1:0] max_q;
  logic [SAMPLE_BITS-1:0] min_q;
  logic [CNT_W-1:0]       max_age_q;
  logic [CNT_W-1:0]       min_age_q;
  logic                   rsc_max_q;
  logic                   rsc_min_q;

  // rescan
  logic [CNT_W-1:0]       pos_q;
  logic [IDX_W-1:0]       scan_addr_q;
  logic [SAMPLE_BITS-1:0] best_max_q;
  logic [SAMPLE_BITS-1:0] best_min_q;
  logic [IDX_W-1:0]       best_max_pos_q;
  logic [IDX_W-1:0]       best_min_pos_q;

  // ring memory
  logic [SAMPLE_BITS-1:0] ring_q [WINDOW];
  logic [SAMPLE_BITS-1:0] rd_data_q;
  logic                   rd_en;
  logic [IDX_W-1:0]       rd_addr;
  logic [IDX_W-1:0]       oldest;
  logic [CNT_W:0]         head_ext;
  logic [CNT_W:0]         cnt_ext;
  logic [CNT_W:0]         oldest_ext;

  // output register
  logic                   out_valid_q;
  logic [SAMPLE_BITS-1:0] out_mean_q;
  logic [SAMPLE_BITS-1:0] out_max_q;
  logic [SAMPLE_BITS-1:0] out_min_q;
  logic [CNT_W-1:0]       out_cnt_q;
  logic                   out_full;

  // misc
  logic                   accept;
  logic                   is_full;
  logic                   rsc_max_w;
  logic                   rsc_min_w;
  logic                   scan_more;
  logic                   div_busy;
  logic [SAMPLE_BITS-1:0] div_quot;

  function automatic logic [IDX_W-1:0] ring_inc(logic [IDX_W-1:0] a);
    return (a == LAST_IDX) ? '0 : a + IDX_W'(1);
  endfunction

  // control word and next step
  assign cw        = swmm_rom(step_q);
  assign accept    = s_axis_tvalid & cw.in_rdy;
  assign is_full   = (count_q == FULL_CNT);
  assign rsc_max_w = (max_age_q >= count_q);
  assign rsc_min_w = (min_age_q >= count_q);
  assign scan_more = (CNT_W'(pos_q + CNT_W'(1)) != count_q);
  assign out_full  = out_valid_q & ~m_axis_tready;

  always_comb begin
    unique case (cw.cond)
      JC_NONE:      jump = 1'b0;
      JC_NO_IN:     jump = ~s_axis_tvalid;
      JC_NO_SCAN:   jump = ~(rsc_max_w | rsc_min_w);
      JC_SCAN_MORE: jump = scan_more;
      JC_DIV_BUSY:  jump = div_busy;
      JC_OUT_FULL:  jump = out_full;
      default:      jump = 1'b0;
    endcase
    step_d = jump ? cw.target : swmm_step_e'(step_q + 3'd1);
  end

  // oldest held slot, wrapping around the ring
  assign head_ext   = (CNT_W + 1)'(head_q);
  assign cnt_ext    = (CNT_W + 1)'(count_q);
  assign oldest_ext = (head_ext >= cnt_ext) ? head_ext - cnt_ext
                                            : head_ext + (CNT_W + 1)'(WINDOW) - cnt_ext;
  assign oldest     = oldest_ext[IDX_W-1:0];

  // ring read port select
  assign rd_en = cw.ev_rd | cw.scan_init | cw.scan_step;
  always_comb begin
    if (cw.ev_rd) begin
      rd_addr = head_q;
    end else if (cw.scan_init) begin
      rd_addr = oldest;
    end else begin
      rd_addr = scan_addr_q;
    end
  end

  // ring memory
  always_ff @(posedge clk_i) begin
    if (cw.upd) begin
      ring_q[head_q] <= sample_q;
    end
    if (rd_en) begin
      rd_data_q <= ring_q[rd_addr];
    end
  end

  // sequencer, window state and output handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      sum_q       <= '0;
      max_q       <= '0;
      min_q       <= '1;
      max_age_q   <= '0;
      min_age_q   <= '0;
      rsc_max_q   <= 1'b0;
      rsc_min_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      // evict the oldest sample when full, add the new one, track extremes
      if (cw.upd) begin
        sum_q  <= sum_q - (is_full ? SUM_W'(rd_data_q) : '0) + SUM_W'(sample_q);
        head_q <= ring_inc(head_q);
        if (!is_full) begin
          count_q <= count_q + CNT_W'(1);
        end
        if (sample_q > max_q) begin
          max_q     <= sample_q;
          max_age_q <= '0;
        end
        if (sample_q < min_q) begin
          min_q     <= sample_q;
          min_age_q <= '0;
        end
      end
      // note which extremes have left the window
      if (cw.chk) begin
        rsc_max_q <= rsc_max_w;
        rsc_min_q <= rsc_min_w;
      end
      // take the rescan results
      if (cw.load) begin
        if (rsc_max_q) begin
          max_q     <= best_max_q;
          max_age_q <= CNT_W'(count_q - CNT_W'(1) - CNT_W'(best_max_pos_q));
        end
        if (rsc_min_q) begin
          min_q     <= best_min_q;
          min_age_q <= CNT_W'(count_q - CNT_W'(1) - CNT_W'(best_min_pos_q));
        end
      end
      // hand the result over and age both extremes
      if (cw.fin && !out_full) begin
        out_valid_q <= 1'b1;
        max_age_q   <= max_age_q + CNT_W'(1);
        min_age_q   <= min_age_q + CNT_W'(1);
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // sample capture, scan datapath and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= s_axis_tdata[SAMPLE_BITS-1:0];
    end
    if (cw.scan_init) begin
      pos_q       <= '0;
      scan_addr_q <= ring_inc(oldest);
    end
    if (cw.scan_step) begin
      pos_q       <= pos_q + CNT_W'(1);
      scan_addr_q <= ring_inc(scan_addr_q);
      // oldest entry seeds both, later ones replace only on strict compare
      if (pos_q == '0 || rd_data_q > best_max_q) begin
        best_max_q     <= rd_data_q;
        best_max_pos_q <= pos_q[IDX_W-1:0];
      end
      if (pos_q == '0 || rd_data_q < best_min_q) begin
        best_min_q     <= rd_data_q;
        best_min_pos_q <= pos_q[IDX_W-1:0];
      end
    end
    if (cw.fin && !out_full) begin
      out_mean_q <= div_quot;
      out_max_q  <= max_q;
      out_min_q  <= min_q;
      out_cnt_q  <= count_q;
    end
  end

  // mean divider
  swmm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cw.chk),
    .dividend_i (sum_q),
    .divisor_i  (count_q),
    .busy_o     (div_busy),
    .quotient_o (div_quot)
  );

  // stream ports
  assign s_axis_tready = cw.in_rdy;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'({out_cnt_q, out_min_q, out_max_q, out_mean_q});

  // checks
  `SWMM_ASSERT_NEXT(a_accept_to_evict, accept, step_q == ST_EVRD)
  `SWMM_ASSERT_IMPL(a_cnt_range, m_axis_tvalid, out_cnt_q != '0 && out_cnt_q <= FULL_CNT)
  `SWMM_ASSERT_IMPL(a_age_range, step_q == ST_IDLE, max_age_q <= count_q && min_age_q <= count_q)
  `SWMM_ASSERT_IMPL(a_extreme_order, step_q == ST_IDLE && count_q != '0, max_q >= min_q)
  `SWMM_ASSERT_IMPL(a_scan_bound, step_q == ST_SCANL, pos_q < count_q)
  `SWMM_ASSERT_IMPL(a_div_done, step_q == ST_FIN, !div_busy)

endmodule

@@ tb/tb_sliding_window_min_max_mean.sv @@
// self-checking testbench for the sliding window min/max/mean block: a directed
// table and random runs, each result item checked against a typed-in row or
// a local window predictor; depends on swmm_pkg and sliding_window_min_max_mean
module tb_sliding_window_min_max_mean;
  import swmm_pkg::*;

  localparam int      CYCLE_LIMIT = 1_000_000;
  localparam int      RANDOM_ITEMS = 700;
  localparam int      DRAIN_CYCLES = 300;
  localparam logic [SAMPLE_BITS-1:0] ALL_ONES = '1;

  // idling phases
  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  // shapes of the random sample runs
  typedef enum int {
    RUN_UNIFORM,
    RUN_NARROW,
    RUN_FALLING,
    RUN_RISING,
    RUN_FLAT,
    RUN_EXTREMES
  } run_shape_e;

  typedef struct {
    logic [SAMPLE_BITS-1:0] mean;
    logic [SAMPLE_BITS-1:0] maximum;
    logic [SAMPLE_BITS-1:0] minimum;
    logic [CNT_W-1:0]       held;
  } window_result_t;

  // directed row: sample item and, where obvious, the result it must give
  typedef struct packed {
    logic [IN_TDATA_W-1:0]  tdata;
    logic                   known;
    logic [SAMPLE_BITS-1:0] mean;
    logic [SAMPLE_BITS-1:0] maximum;
    logic [SAMPLE_BITS-1:0] minimum;
    logic [CNT_W-1:0]       held;
  } sample_row_t;

  localparam int DIR_ROWS = 18;
  localparam sample_row_t DIR_TABLE [DIR_ROWS] = '{
    // first sample after reset is all ones: both extremes take it
    '{24'h0FFFFF, 1'b1, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 9'd1},
    // zero pulls the minimum down and halves the mean
    '{24'h000000, 1'b1, 20'h7FFFF, 20'hFFFFF, 20'h00000, 9'd2},
    // padding bits above the sample are ignored
    '{24'hF00000, 1'b0, '0, '0, '0, '0},
    '{24'h000001, 1'b0, '0, '0, '0, '0},
    '{24'h080000, 1'b0, '0, '0, '0, '0},
    '{24'h080000, 1'b0, '0, '0, '0, '0},
    // equal to the held maximum and minimum
    '{24'h0FFFFF, 1'b0, '0, '0, '0, '0},
    '{24'h000000, 1'b0, '0, '0, '0, '0},
    '{24'hA55AA5, 1'b0, '0, '0, '0, '0},
    '{24'h5AA55A, 1'b0, '0, '0, '0, '0},
    '{24'h07FFFF, 1'b0, '0, '0, '0, '0},
    '{24'hFFFFFF, 1'b0, '0, '0, '0, '0},
    '{24'h300100, 1'b0, '0, '0, '0, '0},
    '{24'h0AAAAA, 1'b0, '0, '0, '0, '0},
    '{24'h055555, 1'b0, '0, '0, '0, '0},
    '{24'hCFFFFE, 1'b0, '0, '0, '0, '0},
    '{24'h000002, 1'b0, '0, '0, '0, '0},
    '{24'h03C000, 1'b0, '0, '0, '0, '0}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  idle_mode_e     idle_mode = IDLE_NONE;
  window_result_t pending_results [$];
  int             fail_count  = 0;
  int             cycle_count = 0;

  // predictor state: ring, running sum and both extremes with ages
  logic [SAMPLE_BITS-1:0] win_ring [WINDOW];
  logic [IDX_W-1:0]       win_head  = '0;
  logic [CNT_W-1:0]       win_count = '0;
  logic [SUM_W-1:0]       win_sum   = '0;
  logic [SAMPLE_BITS-1:0] top_val   = '0;
  logic [CNT_W-1:0]       top_age   = '0;
  logic [SAMPLE_BITS-1:0] bot_val   = ALL_ONES;
  logic [CNT_W-1:0]       bot_age   = '0;

  sliding_window_min_max_mean u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // append one expected result item
  function automatic void queue_result(input window_result_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  // rescan held samples oldest to newest, first occurrence of the extreme wins
  function automatic void rescan_extreme(input bit want_top);
    logic [IDX_W-1:0]       oldest;
    logic [SAMPLE_BITS-1:0] best;
    logic [SAMPLE_BITS-1:0] v;
    logic [CNT_W-1:0]       best_pos;
    oldest   = win_head - win_count[IDX_W-1:0];
    best     = win_ring[oldest];
    best_pos = '0;
    for (int k = 1; k < win_count; k++) begin
      v = win_ring[IDX_W'(oldest + k)];
      if (want_top ? (v > best) : (v < best)) begin
        best     = v;
        best_pos = CNT_W'(k);
      end
    end
    if (want_top) begin
      top_val = best;
      top_age = win_count - 1'b1 - best_pos;
    end else begin
      bot_val = best;
      bot_age = win_count - 1'b1 - best_pos;
    end
  endfunction

  // advance the window by one sample and return mean, extremes and count
  function automatic window_result_t window_step(input logic [IN_TDATA_W-1:0] d);
    logic [SAMPLE_BITS-1:0] s;
    window_result_t         r;
    s = d[SAMPLE_BITS-1:0];
    // full window: evict the oldest before adding
    if (win_count == CNT_W'(WINDOW)) begin
      win_sum = win_sum - win_ring[win_head];
    end else begin
      win_count = win_count + 1'b1;
    end
    win_ring[win_head] = s;
    win_sum  = win_sum + s;
    win_head = win_head + 1'b1;
    r.mean = SAMPLE_BITS'(win_sum / win_count);
    // maximum, with aging and rescan
    if (s > top_val) begin
      top_val = s;
      top_age = '0;
    end
    if (top_age > win_count - 1'b1) rescan_extreme(1'b1);
    top_age = top_age + 1'b1;
    // minimum, same scheme
    if (s < bot_val) begin
      bot_val = s;
      bot_age = '0;
    end
    if (bot_age > win_count - 1'b1) rescan_extreme(1'b0);
    bot_age = bot_age + 1'b1;
    r.maximum = top_val;
    r.minimum = bot_val;
    r.held    = win_count;
    return r;
  endfunction

  function automatic bit sender_idles();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(99) < 88;
      IDLE_BOTH:   return $urandom_range(99) < 26;
      default:     return 1'b0;
    endcase
  endfunction

  // offer one sample item, return at the falling edge after it is taken
  task automatic send_sample(input logic [IN_TDATA_W-1:0] d);
    while (sender_idles()) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // receiver stall pattern, updated at each falling edge
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      case (idle_mode)
        IDLE_RECEIVER: m_axis_tready <= ($urandom_range(99) >= 88);
        IDLE_BOTH:     m_axis_tready <= ($urandom_range(99) >= 26);
        default:       m_axis_tready <= 1'b1;
      endcase
    end
  end

  // compare each result item with the oldest expectation
  always @(posedge clk_i) begin
    window_result_t got;
    window_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.mean    = m_axis_tdata[19:0];
      got.maximum = m_axis_tdata[39:20];
      got.minimum = m_axis_tdata[59:40];
      got.held    = m_axis_tdata[68:60];
      if (pending_results.size() == 0) begin
        $error("result item with nothing expected: %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.mean !== want.mean) begin
          $error("window_mean: expected %h, got %h", want.mean, got.mean);
          fail_count++;
        end
        if (got.maximum !== want.maximum) begin
          $error("window_max: expected %h, got %h", want.maximum, got.maximum);
          fail_count++;
        end
        if (got.minimum !== want.minimum) begin
          $error("window_min: expected %h, got %h", want.minimum, got.minimum);
          fail_count++;
        end
        if (got.held !== want.held) begin
          $error("held_count: expected %0d, got %0d", want.held, got.held);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // stimulus
  initial begin
    window_result_t         predicted;
    window_result_t         typed_in;
    run_shape_e             shape;
    logic [SAMPLE_BITS-1:0] level;
    logic [SAMPLE_BITS-1:0] stride;
    logic [IN_TDATA_W-1:0]  d;
    int                     sent;
    int                     run_len;
    int                     run_idx;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table, no idling
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_sample(DIR_TABLE[i].tdata);
      predicted = window_step(DIR_TABLE[i].tdata);
      if (DIR_TABLE[i].known) begin
        typed_in.mean    = DIR_TABLE[i].mean;
        typed_in.maximum = DIR_TABLE[i].maximum;
        typed_in.minimum = DIR_TABLE[i].minimum;
        typed_in.held    = DIR_TABLE[i].held;
        queue_result(typed_in);
      end else begin
        queue_result(predicted);
      end
    end

    // random runs of varied shape, idling phase rotates per run
    sent    = 0;
    run_idx = 0;
    while (sent < RANDOM_ITEMS) begin
      idle_mode = idle_mode_e'(run_idx % 4);
      shape     = run_shape_e'($urandom_range(5));
      level     = SAMPLE_BITS'($urandom());
      stride    = SAMPLE_BITS'($urandom_range(($urandom_range(1)) ? 1023 : 7));
      if (shape == RUN_FALLING || shape == RUN_RISING) begin
        run_len = $urandom_range(20, 300);
      end else begin
        run_len = $urandom_range(20, 90);
      end
      // last run stops at the item budget
      if (run_len > RANDOM_ITEMS - sent) begin
        run_len = RANDOM_ITEMS - sent;
      end
      for (int j = 0; j < run_len; j++) begin
        case (shape)
          RUN_UNIFORM:  d = IN_TDATA_W'($urandom());
          RUN_NARROW:   d = IN_TDATA_W'(level + $urandom_range(3));
          RUN_FALLING:  begin level = level - stride; d = IN_TDATA_W'(level); end
          RUN_RISING:   begin level = level + stride; d = IN_TDATA_W'(level); end
          RUN_FLAT:     d = IN_TDATA_W'(level);
          default: begin
            case ($urandom_range(2))
              0:       d = '0;
              1:       d = IN_TDATA_W'(ALL_ONES);
              default: d = IN_TDATA_W'($urandom());
            endcase
          end
        endcase
        // now and then set the padding bits above the sample
        if ($urandom_range(7) == 0) begin
          d[IN_TDATA_W-1:SAMPLE_BITS] = (IN_TDATA_W - SAMPLE_BITS)'($urandom());
        end
        send_sample(d);
        queue_result(window_step(d));
        sent++;
      end
      run_idx++;
    end
    s_axis_tvalid <= 1'b0;

    // drain, then allow for a late extra item
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/swmm_pkg.sv
src/swmm_div.sv
src/sliding_window_min_max_mean.sv
tb/tb_sliding_window_min_max_mean.sv
